### design/wlpm_pkg.sv
package wlpm_pkg;

  localparam int MAX_PHRASES_DEF    = 8;
  localparam int MAX_PHRASE_LEN_DEF = 64;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 3;
  localparam int CPOS_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int PLEN_W  = 7;
  localparam int COUNT_W = 4;
  localparam int INDEX_W = 3;
  localparam int LINE_W  = 32;

  localparam logic [OP_W-1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_LEN   = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA      = 2'd2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

  // One request as it travels down the row of phrase cells.
  typedef struct packed {
    logic                valid;
    logic                is_load;
    logic                is_len;
    logic                is_data;
    logic                newline;
    logic [SLOT_W-1:0]   slot;
    logic [CPOS_W-1:0]   char_pos;
    logic [BYTE_W-1:0]   data;
    logic [PLEN_W-1:0]   len;
    logic [COUNT_W-1:0]  used;
    logic [LINE_W-1:0]   line_number;
  } tok_t;

endpackage

### design/wlpm_head.sv
module wlpm_head #(
  parameter int MAX_PHRASE_LEN = wlpm_pkg::MAX_PHRASE_LEN_DEF,
  parameter int LW = $clog2(MAX_PHRASE_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [wlpm_pkg::OP_W-1:0]     op,
  input  logic [wlpm_pkg::SLOT_W-1:0]   phrase_slot,
  input  logic [wlpm_pkg::CPOS_W-1:0]   char_position,
  input  logic [wlpm_pkg::BYTE_W-1:0]   byte_value,
  input  logic [wlpm_pkg::PLEN_W-1:0]   phrase_len,
  input  logic [wlpm_pkg::COUNT_W-1:0]  slot_count,
  output wlpm_pkg::tok_t                tok,
  output logic [LW-1:0]                 pos
);

  logic [LW-1:0]               line_pos;
  logic [LW-1:0]               line_pos_next;
  logic [wlpm_pkg::LINE_W-1:0] line_total;
  logic [wlpm_pkg::LINE_W-1:0] line_total_next;
  logic                        is_load;
  logic                        is_len;
  logic                        is_data;
  logic                        newline;

  always_comb begin
    is_load = 1'b0;
    is_len  = 1'b0;
    is_data = 1'b0;
    unique case (op)
      wlpm_pkg::OP_LOAD_BYTE: is_load = 1'b1;
      wlpm_pkg::OP_SET_LEN:   is_len  = 1'b1;
      wlpm_pkg::OP_DATA:      is_data = 1'b1;
      default: ;
    endcase
  end

  assign newline = (byte_value == wlpm_pkg::NEWLINE_BYTE);

  // The counter stops at its largest value; later lines report that number.
  always_comb begin
    if (line_total == '1) begin
      line_total_next = line_total;
    end else begin
      line_total_next = line_total + 1'b1;
    end
  end

  always_comb begin
    if (newline) begin
      line_pos_next = '0;
    end else if (line_pos < LW'(MAX_PHRASE_LEN)) begin
      line_pos_next = line_pos + 1'b1;
    end else begin
      line_pos_next = line_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos   <= '0;
      line_total <= '0;
    end else if (accept && is_data) begin
      line_pos <= line_pos_next;
      if (newline) begin
        line_total <= line_total_next;
      end
    end
  end

  always_comb begin
    tok.valid       = accept;
    tok.is_load     = is_load;
    tok.is_len      = is_len;
    tok.is_data     = is_data;
    tok.newline     = newline;
    tok.slot        = phrase_slot;
    tok.char_pos    = char_position;
    tok.data        = byte_value;
    tok.len         = phrase_len;
    tok.used        = slot_count;
    tok.line_number = line_total_next;
  end

  assign pos = line_pos;

endmodule

### design/wlpm_cell.sv
module wlpm_cell #(
  parameter int CELL_ID        = 0,
  parameter int MAX_PHRASES    = wlpm_pkg::MAX_PHRASES_DEF,
  parameter int MAX_PHRASE_LEN = wlpm_pkg::MAX_PHRASE_LEN_DEF,
  parameter int LW = $clog2(MAX_PHRASE_LEN + 1),
  parameter int PW = (MAX_PHRASE_LEN > 1) ? $clog2(MAX_PHRASE_LEN) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  wlpm_pkg::tok_t          tok_in,
  input  logic [LW-1:0]           pos_in,
  input  logic [MAX_PHRASES-1:0]  hits_in,
  output wlpm_pkg::tok_t          tok_out,
  output logic [LW-1:0]           pos_out,
  output logic [MAX_PHRASES-1:0]  hits_out
);

  logic [wlpm_pkg::BYTE_W-1:0] mem [MAX_PHRASE_LEN];
  logic [wlpm_pkg::BYTE_W-1:0] stored_byte;
  wlpm_pkg::tok_t              cur_tok;
  logic [LW-1:0]               cur_pos;
  logic [MAX_PHRASES-1:0]      cur_hits;
  logic [LW-1:0]               slot_len;
  logic                        alive;
  logic                        my_slot_in;
  logic                        in_use;
  logic                        is_data_tok;
  logic                        hit;
  logic                        mismatch;
  logic [LW-1:0]               len_sat;
  logic [MAX_PHRASES-1:0]      hit_bit;

  assign my_slot_in  = (32'(tok_in.slot) == CELL_ID);
  assign in_use      = (CELL_ID < 32'(cur_tok.used));
  assign is_data_tok = cur_tok.valid && cur_tok.is_data;
  assign len_sat     = (32'(tok_in.len) > MAX_PHRASE_LEN) ? LW'(MAX_PHRASE_LEN)
                                                         : LW'(tok_in.len);

  // Past the phrase length covers the overlong line too, since slot_len never
  // exceeds the maximum phrase length.
  assign mismatch = (cur_pos >= slot_len) || (stored_byte != cur_tok.data);
  assign hit      = is_data_tok && cur_tok.newline && alive && in_use &&
                    (slot_len == cur_pos);

  always_comb begin
    hit_bit          = '0;
    hit_bit[CELL_ID] = hit;
  end

  // Loads are written as they enter, and every request reads the byte at its
  // line position on entry, so the compare stage sees loads in request order.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (tok_in.valid && tok_in.is_load && my_slot_in &&
          (32'(tok_in.char_pos) < MAX_PHRASE_LEN)) begin
        mem[PW'(tok_in.char_pos)] <= tok_in.data;
      end
      stored_byte <= mem[PW'(pos_in)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_tok.valid <= 1'b0;
      slot_len      <= '0;
      alive         <= 1'b1;
    end else if (advance) begin
      cur_tok <= tok_in;
      if (tok_in.valid && tok_in.is_len && my_slot_in) begin
        slot_len <= len_sat;
      end
      if (is_data_tok) begin
        if (cur_tok.newline) begin
          alive <= 1'b1;
        end else if (mismatch) begin
          alive <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur_pos  <= pos_in;
      cur_hits <= hits_in;
    end
  end

  assign tok_out  = cur_tok;
  assign pos_out  = cur_pos;
  assign hits_out = cur_hits | hit_bit;

endmodule

### design/wlpm_out.sv
module wlpm_out #(
  parameter int MAX_PHRASES = wlpm_pkg::MAX_PHRASES_DEF,
  parameter int SW = (MAX_PHRASES > 1) ? $clog2(MAX_PHRASES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wlpm_pkg::tok_t                tail_tok,
  input  logic [MAX_PHRASES-1:0]        tail_hits,
  output logic                          hold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wlpm_pkg::INDEX_W-1:0]  phrase_index,
  output logic [wlpm_pkg::LINE_W-1:0]   line_number,
  output logic                          last
);

  logic [MAX_PHRASES-1:0]      pending;
  logic [wlpm_pkg::LINE_W-1:0] pending_line;
  logic [MAX_PHRASES-1:0]      remaining;
  logic [SW-1:0]               idx;
  logic                        take;
  logic                        free;
  logic                        push;

  always_comb begin
    idx = '0;
    for (int i = MAX_PHRASES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        idx = SW'(i);
      end
    end
  end

  assign remaining = pending & (pending - 1'b1);
  assign out_valid = |pending;
  assign last      = (remaining == '0);
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && last);
  assign push      = tail_tok.valid && tail_tok.is_data && tail_tok.newline && (|tail_hits);

  // A newline with matches may leave the row only when the previous line's
  // results are gone or the final one is taken in this cycle.
  assign hold = push && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (push && free) begin
      pending <= tail_hits;
    end else if (take) begin
      pending <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      pending_line <= tail_tok.line_number;
    end
  end

  assign phrase_index = wlpm_pkg::INDEX_W'(idx);
  assign line_number  = pending_line;

endmodule

### design/whole_line_phrase_matcher_unit.sv
// Whole-line phrase matcher: text bytes stream in one per cycle and every line
// that equals one of the loaded phrases is reported as one result per matching
// slot, in slot order, with last set on the final one. Each phrase slot is a
// cell in a row; a request moves one cell per cycle unless the row is held, and
// the first result of a line is offered once its newline has passed every cell
// and the output register, or later while the previous line's results drain.
// The input takes one request per cycle while in_stall is low; results leave
// one per cycle while out_stall is low, so a newline with matches can hold the
// input, longer while out_stall is high, when the next matching newline reaches
// the end of the row before they are all taken. Phrase bytes and lengths come
// in on the input channel, the slot count on the always-ready cfg channel; the
// user must write it only while idle, which the block does not enforce.
module whole_line_phrase_matcher_unit #(
  parameter int MAX_PHRASES    = wlpm_pkg::MAX_PHRASES_DEF,
  parameter int MAX_PHRASE_LEN = wlpm_pkg::MAX_PHRASE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wlpm_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wlpm_pkg::OP_W-1:0]     op,
  input  logic [wlpm_pkg::SLOT_W-1:0]   phrase_slot,
  input  logic [wlpm_pkg::CPOS_W-1:0]   char_position,
  input  logic [wlpm_pkg::BYTE_W-1:0]   byte_value,
  input  logic [wlpm_pkg::PLEN_W-1:0]   phrase_len,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wlpm_pkg::INDEX_W-1:0]  phrase_index,
  output logic [wlpm_pkg::LINE_W-1:0]   line_number,
  output logic                          last
);

  localparam int LW = $clog2(MAX_PHRASE_LEN + 1);

  logic [wlpm_pkg::COUNT_W-1:0] slot_count;
  logic                         hold;
  logic                         advance;
  logic                         accept;
  wlpm_pkg::tok_t               tok  [MAX_PHRASES + 1];
  logic [LW-1:0]                pos  [MAX_PHRASES + 1];
  logic [MAX_PHRASES-1:0]       hits [MAX_PHRASES + 1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= wlpm_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_count <= cfg_data;
    end
  end

  assign advance  = !hold;
  assign in_stall = hold;
  assign accept   = in_valid && advance;

  wlpm_head #(
    .MAX_PHRASE_LEN(MAX_PHRASE_LEN),
    .LW(LW)
  ) u_head (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .op(op),
    .phrase_slot(phrase_slot),
    .char_position(char_position),
    .byte_value(byte_value),
    .phrase_len(phrase_len),
    .slot_count(slot_count),
    .tok(tok[0]),
    .pos(pos[0])
  );

  assign hits[0] = '0;

  for (genvar i = 0; i < MAX_PHRASES; i++) begin : g_cell
    wlpm_cell #(
      .CELL_ID(i),
      .MAX_PHRASES(MAX_PHRASES),
      .MAX_PHRASE_LEN(MAX_PHRASE_LEN),
      .LW(LW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .advance(advance),
      .tok_in(tok[i]),
      .pos_in(pos[i]),
      .hits_in(hits[i]),
      .tok_out(tok[i+1]),
      .pos_out(pos[i+1]),
      .hits_out(hits[i+1])
    );
  end

  wlpm_out #(
    .MAX_PHRASES(MAX_PHRASES)
  ) u_out (
    .clk(clk),
    .rst(rst),
    .tail_tok(tok[MAX_PHRASES]),
    .tail_hits(hits[MAX_PHRASES]),
    .hold(hold),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .phrase_index(phrase_index),
    .line_number(line_number),
    .last(last)
  );

endmodule

### bench/whole_line_phrase_matcher_checker.sv
module whole_line_phrase_matcher_checker #(
  parameter int MAX_PHRASES    = wlpm_pkg::MAX_PHRASES_DEF,
  parameter int MAX_PHRASE_LEN = wlpm_pkg::MAX_PHRASE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [wlpm_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [wlpm_pkg::OP_W-1:0]    op,
  input  logic [wlpm_pkg::SLOT_W-1:0]  phrase_slot,
  input  logic [wlpm_pkg::CPOS_W-1:0]  char_position,
  input  logic [wlpm_pkg::BYTE_W-1:0]  byte_value,
  input  logic [wlpm_pkg::PLEN_W-1:0]  phrase_len,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [wlpm_pkg::INDEX_W-1:0] phrase_index,
  input  logic [wlpm_pkg::LINE_W-1:0]  line_number,
  input  logic                         last,
  output int                           mismatches,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [wlpm_pkg::INDEX_W-1:0] slot;
    logic [wlpm_pkg::LINE_W-1:0]  line;
    logic                         last;
  } line_match_t;

  logic [wlpm_pkg::BYTE_W-1:0]  phrase_bytes [MAX_PHRASES][MAX_PHRASE_LEN];
  logic [wlpm_pkg::PLEN_W-1:0]  slot_len [MAX_PHRASES];
  logic [MAX_PHRASES-1:0]       alive;
  logic [wlpm_pkg::PLEN_W-1:0]  line_pos;
  logic [wlpm_pkg::LINE_W-1:0]  lines_seen;
  logic [wlpm_pkg::COUNT_W-1:0] slot_count;
  line_match_t                  expected_matches [$];

  task automatic clear_matcher();
    foreach (slot_len[s]) slot_len[s] = '0;
    alive        = '1;
    line_pos     = '0;
    lines_seen   = '0;
    slot_count   = wlpm_pkg::COUNT_RESET;
    expected_matches.delete();
    mismatches   = 0;
  endtask

  // Applies one accepted request to the matcher state and queues the line
  // matches that it produces.
  task automatic track_request(input logic [wlpm_pkg::OP_W-1:0] kind,
                               input logic [wlpm_pkg::SLOT_W-1:0] slot,
                               input logic [wlpm_pkg::CPOS_W-1:0] cpos,
                               input logic [wlpm_pkg::BYTE_W-1:0] val,
                               input logic [wlpm_pkg::PLEN_W-1:0] plen);
    int used;
    int hits [$];
    case (kind)
      wlpm_pkg::OP_LOAD_BYTE: begin
        if (slot < MAX_PHRASES && cpos < MAX_PHRASE_LEN) phrase_bytes[slot][cpos] = val;
      end
      wlpm_pkg::OP_SET_LEN: begin
        if (slot < MAX_PHRASES)
          slot_len[slot] = (plen > MAX_PHRASE_LEN) ? wlpm_pkg::PLEN_W'(MAX_PHRASE_LEN) : plen;
      end
      wlpm_pkg::OP_DATA: begin
        if (val == wlpm_pkg::NEWLINE_BYTE) begin
          if (lines_seen != '1) lines_seen = lines_seen + 1'b1;
          used = (slot_count > MAX_PHRASES) ? MAX_PHRASES : int'(slot_count);
          for (int s = 0; s < used; s++) begin
            if (alive[s] && slot_len[s] == line_pos) hits.push_back(s);
          end
          foreach (hits[i])
            expected_matches.push_back('{wlpm_pkg::INDEX_W'(hits[i]), lines_seen,
                                         i == hits.size() - 1});
          alive    = '1;
          line_pos = '0;
        end else if (line_pos >= MAX_PHRASE_LEN) begin
          alive = '0;
        end else begin
          for (int s = 0; s < MAX_PHRASES; s++) begin
            if (line_pos >= slot_len[s] || phrase_bytes[s][line_pos] != val) alive[s] = 1'b0;
          end
          line_pos = line_pos + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    line_match_t want;
    if (rst) begin
      clear_matcher();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          mismatches++;
          $display("%0t ERROR: no match expected, actual slot %0d line %0d last %0b",
                   $time, phrase_index, line_number, last);
        end else begin
          want = expected_matches.pop_front();
          if (phrase_index !== want.slot || line_number !== want.line ||
              last !== want.last) begin
            mismatches++;
            $display("%0t ERROR: expected slot %0d line %0d last %0b, %s %0d line %0d last %0b",
                     $time, want.slot, want.line, want.last, "actual slot",
                     phrase_index, line_number, last);
          end
        end
      end
      if (cfg_valid && cfg_ready) slot_count = cfg_data;
      if (in_valid && !in_stall)
        track_request(op, phrase_slot, char_position, byte_value, phrase_len);
    end
    outstanding = expected_matches.size();
  end

endmodule

### bench/tb_whole_line_phrase_matcher_unit.sv
module tb_whole_line_phrase_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wlpm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NPH = wlpm_pkg::MAX_PHRASES_DEF;
  localparam int NLEN = wlpm_pkg::MAX_PHRASE_LEN_DEF;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [wlpm_pkg::COUNT_W-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [wlpm_pkg::OP_W-1:0]    op = '0;
  logic [wlpm_pkg::SLOT_W-1:0]  phrase_slot = '0;
  logic [wlpm_pkg::CPOS_W-1:0]  char_position = '0;
  logic [wlpm_pkg::BYTE_W-1:0]  byte_value = '0;
  logic [wlpm_pkg::PLEN_W-1:0]  phrase_len = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [wlpm_pkg::INDEX_W-1:0] phrase_index;
  logic [wlpm_pkg::LINE_W-1:0]  line_number;
  logic                         last;
  int                           mismatches;
  int                           outstanding;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_served = 1'b0;
  int cycles = 0;
  int counted = 0;
  int slots_on = int'(wlpm_pkg::COUNT_RESET);
  int long_phrases_left = 1;
  int long_lines_left = 2;

  // Stimulus-side copy of the loaded phrases, used to build lines that match.
  logic [wlpm_pkg::BYTE_W-1:0] shadow_text [NPH][NLEN];
  bit                          shadow_written [NPH][NLEN];
  int                          shadow_len [NPH];

  whole_line_phrase_matcher_unit dut (.*);
  whole_line_phrase_matcher_checker match_scoreboard (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stall bursts, quiet stretches and one long hold-off.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  function automatic logic [wlpm_pkg::BYTE_W-1:0] random_text_byte();
    logic [wlpm_pkg::BYTE_W-1:0] b;
    b = wlpm_pkg::BYTE_W'($urandom);
    return (b == wlpm_pkg::NEWLINE_BYTE) ? 8'h20 : b;
  endfunction

  task automatic push_request(input logic [wlpm_pkg::OP_W-1:0] kind,
                              input logic [wlpm_pkg::SLOT_W-1:0] slot,
                              input logic [wlpm_pkg::CPOS_W-1:0] cpos,
                              input logic [wlpm_pkg::BYTE_W-1:0] val,
                              input logic [wlpm_pkg::PLEN_W-1:0] plen);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= kind;
    phrase_slot   <= slot;
    char_position <= cpos;
    byte_value    <= val;
    phrase_len    <= plen;
    do @(posedge clk); while (in_stall);
    if (kind != OP_UNUSED) counted++;
    if (kind == wlpm_pkg::OP_LOAD_BYTE) begin
      shadow_text[slot][cpos]    = val;
      shadow_written[slot][cpos] = 1'b1;
    end
    if (kind == wlpm_pkg::OP_SET_LEN)
      shadow_len[slot] = (plen > NLEN) ? NLEN : int'(plen);
  endtask

  task automatic load_byte(input logic [wlpm_pkg::SLOT_W-1:0] slot,
                           input logic [wlpm_pkg::CPOS_W-1:0] cpos,
                           input logic [wlpm_pkg::BYTE_W-1:0] val);
    push_request(wlpm_pkg::OP_LOAD_BYTE, slot, cpos, val, wlpm_pkg::PLEN_W'($urandom));
  endtask

  task automatic set_length(input logic [wlpm_pkg::SLOT_W-1:0] slot,
                            input logic [wlpm_pkg::PLEN_W-1:0] plen);
    push_request(wlpm_pkg::OP_SET_LEN, slot, wlpm_pkg::CPOS_W'($urandom),
                 wlpm_pkg::BYTE_W'($urandom), plen);
  endtask

  task automatic text_byte(input logic [wlpm_pkg::BYTE_W-1:0] val);
    push_request(wlpm_pkg::OP_DATA, wlpm_pkg::SLOT_W'($urandom),
                 wlpm_pkg::CPOS_W'($urandom), val, wlpm_pkg::PLEN_W'($urandom));
  endtask

  task automatic send_phrase(input int slot, input logic [wlpm_pkg::BYTE_W-1:0] txt [$],
                             input logic [wlpm_pkg::PLEN_W-1:0] plen);
    foreach (txt[i]) load_byte(wlpm_pkg::SLOT_W'(slot), wlpm_pkg::CPOS_W'(i), txt[i]);
    set_length(wlpm_pkg::SLOT_W'(slot), plen);
  endtask

  // Sends one line and its newline; now and then a phrase byte is loaded mid-line.
  task automatic send_line(input logic [wlpm_pkg::BYTE_W-1:0] txt [$]);
    foreach (txt[i]) begin
      text_byte(txt[i]);
      if ($urandom_range(0, 24) == 0)
        load_byte(wlpm_pkg::SLOT_W'($urandom), wlpm_pkg::CPOS_W'($urandom),
                  random_text_byte());
    end
    text_byte(wlpm_pkg::NEWLINE_BYTE);
  endtask

  task automatic settle();
    int quiet;
    in_valid <= 1'b0;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      quiet = (outstanding == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic write_count(input logic [wlpm_pkg::COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slots_on = int'(value);
  endtask

  task automatic run_traffic(input int quota);
    int start_count;
    int pick;
    int slot;
    int src;
    int n;
    int hi;
    logic [wlpm_pkg::PLEN_W-1:0] plen;
    logic [wlpm_pkg::BYTE_W-1:0] txt [$];
    start_count = counted;
    while (counted - start_count < quota) begin
      pick = $urandom_range(0, 99);
      txt.delete();
      hi = (slots_on > NPH) ? NPH : slots_on;
      if (pick < 14) begin
        slot = $urandom_range(0, NPH - 1);
        src  = $urandom_range(0, NPH - 1);
        if ($urandom_range(0, 1) == 0) begin
          // A copy of another slot's phrase lets one line match several slots.
          for (int i = 0; i < shadow_len[src]; i++) txt.push_back(shadow_text[src][i]);
          plen = wlpm_pkg::PLEN_W'(shadow_len[src]);
        end else begin
          n = (long_phrases_left > 0) ? NLEN : $urandom_range(0, 8);
          if (n == NLEN) long_phrases_left--;
          repeat (n) txt.push_back(random_text_byte());
          plen = (n == NLEN) ? wlpm_pkg::PLEN_W'($urandom_range(NLEN, 127)) :
                               wlpm_pkg::PLEN_W'(n);
        end
        send_phrase(slot, txt, plen);
      end else if (pick < 70) begin
        slot = (hi == 0) ? $urandom_range(0, NPH - 1) : $urandom_range(0, hi - 1);
        for (int i = 0; i < shadow_len[slot]; i++) txt.push_back(shadow_text[slot][i]);
        n = $urandom_range(0, 5);
        if (n == 0) begin
          txt.push_back(random_text_byte());
        end else if (n == 1 && txt.size() > 0) begin
          void'(txt.pop_back());
        end else if (n == 2 && txt.size() > 0) begin
          src = $urandom_range(0, txt.size() - 1);
          txt[src] = txt[src] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_line(txt);
      end else if (pick < 80) begin
        repeat ($urandom_range(0, 6)) txt.push_back(random_text_byte());
        send_line(txt);
      end else if (pick < 84 && long_lines_left > 0) begin
        long_lines_left--;
        repeat ($urandom_range(NLEN + 1, NLEN + 6))
          txt.push_back(random_text_byte());
        send_line(txt);
      end else begin
        n = $urandom_range(0, 3);
        if (n == 0) begin
          push_request(OP_UNUSED, wlpm_pkg::SLOT_W'($urandom), wlpm_pkg::CPOS_W'($urandom),
                       wlpm_pkg::BYTE_W'($urandom), wlpm_pkg::PLEN_W'($urandom));
        end else if (n == 1) begin
          load_byte(wlpm_pkg::SLOT_W'($urandom), wlpm_pkg::CPOS_W'($urandom),
                    wlpm_pkg::BYTE_W'($urandom));
        end else if (n == 2) begin
          // A length may only cover phrase bytes that have already been loaded.
          slot = $urandom_range(0, NPH - 1);
          src  = 0;
          while (src < NLEN && shadow_written[slot][src]) src++;
          set_length(wlpm_pkg::SLOT_W'(slot),
                     (src == NLEN) ? wlpm_pkg::PLEN_W'($urandom_range(0, 127)) :
                                     wlpm_pkg::PLEN_W'($urandom_range(0, src)));
        end else begin
          text_byte(wlpm_pkg::BYTE_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    logic [wlpm_pkg::BYTE_W-1:0] txt [$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_request(OP_UNUSED, '1, '1, '1, '1);
    // The first line is empty and slot zero still has length zero, so it matches.
    text_byte(wlpm_pkg::NEWLINE_BYTE);
    load_byte(3'd7, 6'd63, 8'hFF);
    txt = '{8'h61, 8'h62};
    send_phrase(0, txt, 7'd2);
    send_line(txt);
    txt.push_back(8'h63);
    send_line(txt);
    // Changing a phrase byte already compared must not undo that comparison.
    text_byte(8'h61);
    load_byte(3'd0, 6'd0, 8'h71);
    text_byte(8'h62);
    text_byte(wlpm_pkg::NEWLINE_BYTE);
    load_byte(3'd0, 6'd0, 8'h61);
    txt = '{8'h61};
    send_line(txt);
    set_length(3'd0, 7'd0);
    text_byte(wlpm_pkg::NEWLINE_BYTE);
    settle();

    write_count(4'd8);
    run_traffic(30);
    settle();

    // Every slot matches an empty line while the result side holds off for a
    // long stretch, so the block fills up and stalls its input.
    write_count(4'd15);
    hold_req = 1'b1;
    for (int s = 0; s < NPH; s++) set_length(wlpm_pkg::SLOT_W'(s), 7'd0);
    repeat (20) text_byte(wlpm_pkg::NEWLINE_BYTE);
    settle();
    run_traffic(30);
    settle();

    write_count(4'd0);
    run_traffic(20);
    settle();

    write_count(wlpm_pkg::COUNT_W'($urandom_range(2, 7)));
    run_traffic(30);
    settle();

    write_count(wlpm_pkg::COUNT_RESET);
    run_traffic(20);
    settle();

    write_count(4'd8);
    calm = 1'b1;
    run_traffic(30);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/wlpm_pkg.sv
design/wlpm_head.sv
design/wlpm_cell.sv
design/wlpm_out.sv
design/whole_line_phrase_matcher_unit.sv
bench/whole_line_phrase_matcher_checker.sv
bench/tb_whole_line_phrase_matcher_unit.sv
